[rtl/cpdr_pkg.sv]
// Shared types and constants for the code prologue and data reference scanner.
// Used by every module of the block; depends on nothing else.
package cpdr_pkg;

	// Configuration register indexes
	localparam int unsigned NUM_REGS   = 8;
	localparam int unsigned IDX_W      = 8;
	localparam logic [IDX_W-1:0] REG_CODE_START = 8'd0;
	localparam logic [IDX_W-1:0] REG_CODE_END   = 8'd1;
	localparam logic [IDX_W-1:0] REG_CODE_VBASE = 8'd2;
	localparam logic [IDX_W-1:0] REG_HEADER     = 8'd3;
	localparam logic [IDX_W-1:0] REG_LOAD_BASE  = 8'd4;
	localparam logic [IDX_W-1:0] REG_ENTRY      = 8'd5;
	localparam logic [IDX_W-1:0] REG_DATA_LOW   = 8'd6;
	localparam logic [IDX_W-1:0] REG_DATA_HIGH  = 8'd7;

	// Hit kinds
	localparam logic KIND_PROLOGUE = 1'b0;
	localparam logic KIND_DATA     = 1'b1;

	// Opcode bytes
	localparam logic [7:0] OP_PUSH_EBP = 8'h55;
	localparam logic [7:0] OP_MOV_RM   = 8'h89;
	localparam logic [7:0] OP_MODRM_E5 = 8'hE5;
	localparam logic [7:0] OP_PUSH_EBX = 8'h53;
	localparam logic [7:0] OP_PUSH_ESI = 8'h56;
	localparam logic [7:0] OP_PUSH_EDI = 8'h57;
	localparam logic [7:0] OP_MOV_R    = 8'h8B;
	localparam logic [7:0] OP_MODRM_EC = 8'hEC;
	localparam logic [7:0] OP_MOV_IMM_LO = 8'hB8;
	localparam logic [7:0] OP_MOV_IMM_HI = 8'hC0;

	// Queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register set
	typedef struct packed {
		logic [31:0] code_start;
		logic [31:0] code_end;
		logic [31:0] code_vbase;
		logic [31:0] header;
		logic [31:0] load_base;
		logic [31:0] entry;
		logic [31:0] data_low;
		logic [31:0] data_high;
	} cpdr_cfg_t;

	// Candidate word handed from front to back
	typedef struct packed {
		logic        kind;
		logic [32:0] start;   // start offset, bit 32 flags overflow
		logic [31:0] imm;
	} cpdr_entry_t;

endpackage

[rtl/cpdr_regs.sv]
// Configuration register file of the scanner.
// Depends on cpdr_pkg for register indexes and the register set struct.
module cpdr_regs import cpdr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [31:0]      cfg_data,
	output cpdr_cfg_t        cfg
);

	cpdr_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg         = cfg_q;

	// Decode the index; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CODE_START: cfg_q.code_start <= cfg_data;
				REG_CODE_END:   cfg_q.code_end   <= cfg_data;
				REG_CODE_VBASE: cfg_q.code_vbase <= cfg_data;
				REG_HEADER:     cfg_q.header     <= cfg_data;
				REG_LOAD_BASE:  cfg_q.load_base  <= cfg_data;
				REG_ENTRY:      cfg_q.entry      <= cfg_data;
				REG_DATA_LOW:   cfg_q.data_low   <= cfg_data;
				REG_DATA_HIGH:  cfg_q.data_high  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[rtl/cpdr_front.sv]
// Front end: byte window, stream counter and pattern classification.
// Depends on cpdr_pkg; pushes candidate words into the queue.
module cpdr_front import cpdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cpdr_cfg_t   cfg,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  image_byte,
	input  logic        final_byte,
	input  logic        q_full,
	output logic        q_push,
	output cpdr_entry_t q_data
);

	logic [31:0] window_q;
	logic [31:0] offset_q;
	logic        accept;
	logic [7:0]  b0, b1, b2, b3;
	logic        is_pro;
	logic        is_mov;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	assign b0 = window_q[31:24];
	assign b1 = window_q[23:16];
	assign b2 = window_q[15:8];
	assign b3 = window_q[7:0];

	// Match the three prologue forms and the mov-immediate opcode row.
	always_comb begin
		is_pro = (b0 == OP_PUSH_EBP && b1 == OP_MOV_RM && b2 == OP_MODRM_E5) ||
			(b0 == OP_PUSH_EBX && b1 == OP_PUSH_ESI && b2 == OP_PUSH_EDI &&
			 b3 == OP_PUSH_EBP) ||
			(b0 == OP_PUSH_EBP && b1 == OP_MOV_R && b2 == OP_MODRM_EC);
		is_mov = (b0 >= OP_MOV_IMM_LO) && (b0 < OP_MOV_IMM_HI);
	end

	// A start is judged once its fifth byte arrives; range checks follow in the back end.
	always_comb begin
		q_data.kind  = is_pro ? KIND_PROLOGUE : KIND_DATA;
		q_data.start = {1'b0, cfg.code_start} + {1'b0, offset_q} - 33'd4;
		q_data.imm   = {image_byte, b3, b2, b1};
		q_push       = accept && (offset_q >= 32'd4) && (is_pro || is_mov);
	end

	// Shift the window and count bytes, clearing both after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			offset_q <= '0;
		end else if (accept) begin
			if (final_byte) begin
				window_q <= '0;
				offset_q <= '0;
			end else begin
				window_q <= {window_q[23:0], image_byte};
				if (offset_q != 32'hFFFF_FFFF) begin
					offset_q <= offset_q + 32'd1;
				end
			end
		end
	end

	// The count restarts after a final byte.
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && final_byte |=> offset_q == 32'd0 && window_q == 32'd0)
		else $error("stream state not cleared after final byte");

endmodule

[rtl/cpdr_queue.sv]
// Short queue of candidate words between the front and back ends.
// Depends on cpdr_pkg for the entry type and the queue depth.
module cpdr_queue import cpdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cpdr_entry_t push_data,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output cpdr_entry_t head
);

	cpdr_entry_t       slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty))
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

[rtl/cpdr_back.sv]
// Back end: bound check, address translation, range compares, result register.
// Depends on cpdr_pkg; drains the queue and drives the result channel.
module cpdr_back import cpdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cpdr_cfg_t   cfg,
	input  logic        q_not_empty,
	input  cpdr_entry_t q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit_kind,
	output logic [31:0] hit_value,
	output logic [31:0] hit_offset
);

	logic        valid_s1;
	logic        kind_s1;
	logic        keep_s1;
	logic [31:0] rva_s1;
	logic [31:0] imm_s1;
	logic [31:0] offset_s1;

	logic        out_valid_q;
	logic        kind_q;
	logic [31:0] value_q;
	logic [31:0] offset_q;

	logic        out_free;
	logic        load_s1;
	logic [31:0] s;
	logic        keep;
	logic [31:0] rva;
	logic [31:0] va;
	logic        hit;

	assign out_free = !out_valid_q || !out_stall;
	assign load_s1  = !valid_s1 || out_free;
	assign q_pop    = q_not_empty && load_s1;

	// Stage 1: code end bound and offset to relative address.
	always_comb begin
		s    = q_head.start[31:0];
		keep = !q_head.start[32] && ({2'b00, s} + 34'd2 < {2'b00, cfg.code_end});
		if (s <= cfg.header) begin
			rva = s;
		end else if (s >= cfg.code_start && s <= cfg.code_end) begin
			rva = s - cfg.code_start + cfg.code_vbase;
		end else begin
			rva = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_s1   <= q_head.kind;
			keep_s1   <= keep;
			rva_s1    <= rva;
			imm_s1    <= q_head.imm;
			offset_s1 <= (q_head.kind == KIND_DATA) ? s + 32'd1 : s;
		end
	end

	// Stage 2: absolute address and the entry or data range test.
	always_comb begin
		va = rva_s1 + cfg.load_base;
		if (kind_s1 == KIND_DATA) begin
			hit = keep_s1 && (cfg.data_low <= imm_s1) && (imm_s1 < cfg.data_high);
		end else begin
			hit = keep_s1 && (va > cfg.entry);
		end
	end

	// Result register; misses simply leave it empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			kind_q   <= kind_s1;
			value_q  <= (kind_s1 == KIND_DATA) ? imm_s1 : va;
			offset_q <= offset_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit_kind   = kind_q;
	assign hit_value  = value_q;
	assign hit_offset = offset_q;

endmodule

[rtl/code_prologue_and_data_ref_scan_unit.sv]
// Top level of the code prologue and data reference scanner.
// Depends on cpdr_pkg, cpdr_regs, cpdr_front, cpdr_queue and cpdr_back.
//
// Usage:
//  - The input channel (in_valid / in_stall) carries one image byte per word,
//    in file order from the code section start; final_byte marks the last
//    byte of a stream, after which the window and byte count start over.
//  - The result channel (out_valid / out_stall) carries at most one word per
//    input byte: a function prologue (hit_kind 0) with its virtual address,
//    or a mov-immediate data reference (hit_kind 1) with the immediate.
//  - The configuration channel (cfg_valid / cfg_ready, always ready) writes
//    register cfg_index with cfg_data; indexes beyond the eight registers
//    are ignored. Write only while no byte is still in flight.
//  - Throughput is one byte per cycle while in_stall is low. A result passes
//    from the byte that completes its five-byte window through the candidate
//    queue, the translation stage register and then the result register.
//  - Reset clears the configuration registers, the window, the byte count and the queue.
//  - When the receiver stalls, the result register holds; candidates pile up
//    in a four-entry queue, and in_stall rises only once that queue is full.
module code_prologue_and_data_ref_scan_unit import cpdr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       image_byte,
	input  logic             final_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             hit_kind,
	output logic [31:0]      hit_value,
	output logic [31:0]      hit_offset
);

	cpdr_cfg_t   cfg;
	logic        q_full;
	logic        q_push;
	cpdr_entry_t q_data;
	logic        q_pop;
	logic        q_not_empty;
	cpdr_entry_t q_head;

	// Configuration registers.
	cpdr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Byte window and classification.
	cpdr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.image_byte (image_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	// Candidate queue.
	cpdr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Translation, range checks and result register.
	cpdr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit_kind    (hit_kind),
		.hit_value   (hit_value),
		.hit_offset  (hit_offset)
	);

endmodule

[test/cpdr_scan_checker.sv]
`timescale 1ns / 100ps
// Checker for the code prologue and data reference scanner: watches the three channels,
// predicts each hit word from the accepted bytes and compares it field by field.
// Depends on cpdr_pkg for register indexes, hit kinds and opcode bytes.
module cpdr_scan_checker import cpdr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [7:0]       image_byte,
	input  logic             final_byte,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic             hit_kind,
	input  logic [31:0]      hit_value,
	input  logic [31:0]      hit_offset,
	output int               mismatches,
	output int               hits_pending
);

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic [31:0] offset;
	} scan_hit_t;

	localparam int PRINT_CAP = 40;
	localparam int REG_SEL_W = $clog2(NUM_REGS);

	// Shadow copy of the scanner's registers and stream state
	logic [31:0] cfg_regs [NUM_REGS];
	logic [31:0] window;
	logic [31:0] byte_count;
	scan_hit_t   hits_due [$];
	int          n_mismatch = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (n_mismatch < PRINT_CAP)
			$display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
		n_mismatch++;
	endtask

	// Works out the hit, if any, that judging the oldest window start yields when byte b4
	// arrives, then shifts the byte in.
	task automatic predict_scan_hit(input logic [7:0] b4, input logic fin);
		logic [33:0] s_wide;
		logic [31:0] s;
		logic [31:0] rva;
		logic [31:0] va;
		logic [31:0] imm;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic        is_prologue;
		scan_hit_t   h;
		{b0, b1, b2, b3} = window;
		if (byte_count >= 32'd4) begin
			s_wide = {2'b00, cfg_regs[REG_CODE_START]} + {2'b00, byte_count} - 34'd4;
			// The start must not overflow and must lie more than two bytes short of the code end.
			if (s_wide <= 34'h0_FFFF_FFFF && s_wide + 34'd2 < {2'b00, cfg_regs[REG_CODE_END]}) begin
				s = s_wide[31:0];
				is_prologue = (b0 == OP_PUSH_EBP && b1 == OP_MOV_RM && b2 == OP_MODRM_E5) ||
					(b0 == OP_PUSH_EBX && b1 == OP_PUSH_ESI && b2 == OP_PUSH_EDI &&
					b3 == OP_PUSH_EBP) ||
					(b0 == OP_PUSH_EBP && b1 == OP_MOV_R && b2 == OP_MODRM_EC);
				if (is_prologue) begin
					// Offsets inside the headers map to themselves, code offsets are rebased.
					if (s <= cfg_regs[REG_HEADER])
						rva = s;
					else if (s >= cfg_regs[REG_CODE_START] && s <= cfg_regs[REG_CODE_END])
						rva = s - cfg_regs[REG_CODE_START] + cfg_regs[REG_CODE_VBASE];
					else
						rva = '0;
					va = rva + cfg_regs[REG_LOAD_BASE];
					if (va > cfg_regs[REG_ENTRY]) begin
						h.kind   = KIND_PROLOGUE;
						h.value  = va;
						h.offset = s;
						hits_due.push_back(h);
					end
				end else if (b0 >= OP_MOV_IMM_LO && b0 < OP_MOV_IMM_HI) begin
					imm = {b4, b3, b2, b1};
					if (cfg_regs[REG_DATA_LOW] <= imm && imm < cfg_regs[REG_DATA_HIGH]) begin
						h.kind   = KIND_DATA;
						h.value  = imm;
						h.offset = s + 32'd1;
						hits_due.push_back(h);
					end
				end
			end
		end
		window = {window[23:0], b4};
		if (byte_count != 32'hFFFF_FFFF)
			byte_count++;
		if (fin) begin
			window     = '0;
			byte_count = '0;
		end
	endtask

	// Compares a delivered hit word against the oldest one due.
	task automatic check_hit();
		scan_hit_t want;
		if (hits_due.size() == 0) begin
			report_mismatch("hit word with none due, hit_value", hit_value, '0);
		end else begin
			want = hits_due.pop_front();
			if (hit_kind !== want.kind)
				report_mismatch("hit_kind", {31'd0, hit_kind}, {31'd0, want.kind});
			if (hit_value !== want.value)
				report_mismatch("hit_value", hit_value, want.value);
			if (hit_offset !== want.offset)
				report_mismatch("hit_offset", hit_offset, want.offset);
		end
	endtask

	// Result words are checked before the byte of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				cfg_regs[i] = '0;
			window     = '0;
			byte_count = '0;
			hits_due.delete();
			hits_pending <= 0;
			mismatches   <= n_mismatch;
		end else begin
			if (out_valid && !out_stall)
				check_hit();
			if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
				cfg_regs[cfg_index[REG_SEL_W-1:0]] = cfg_data;
			if (in_valid && !in_stall)
				predict_scan_hit(image_byte, final_byte);
			hits_pending <= hits_due.size();
			mismatches   <= n_mismatch;
		end
	end

endmodule

[test/code_prologue_and_data_ref_scan_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the code prologue and data reference scanner: drives register
// settings and byte streams, stalls the result side, and gives the verdict.
// Depends on cpdr_pkg, the scanner top level and cpdr_scan_checker.
module code_prologue_and_data_ref_scan_unit_tb;
	import cpdr_pkg::*;

	localparam int          TARGET_ITEMS  = 930;
	localparam int          SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	typedef enum int {SET_ZERO, SET_ONES, SET_OVERFLOW, SET_SHORT, SET_TYPICAL} setting_e;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_e;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [31:0]      cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       image_byte = '0;
	logic             final_byte = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             hit_kind;
	logic [31:0]      hit_value;
	logic [31:0]      hit_offset;
	int               mismatches;
	int               hits_pending;

	int unsigned      cycle_count = 0;
	int               items_sent = 0;
	int               burst_left = 0;
	int               gap_max = 0;
	logic [31:0]      data_lo = '0;
	logic [31:0]      data_hi = '0;
	logic [7:0]       stream_q [$];

	code_prologue_and_data_ref_scan_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.image_byte (image_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit_kind   (hit_kind),
		.hit_value  (hit_value),
		.hit_offset (hit_offset)
	);

	cpdr_scan_checker scan_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.image_byte   (image_byte),
		.final_byte   (final_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit_kind     (hit_kind),
		.hit_value    (hit_value),
		.hit_offset   (hit_offset),
		.mismatches   (mismatches),
		.hits_pending (hits_pending)
	);

	// Clock and cycle counter.
	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// The run is cut off if it takes far longer than the slowest correct run.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// The result side stalls in random modes, each held for a random span.
	initial begin
		stall_mode_e mode;
		int          span;
		int          run_left;
		logic        run_level;
		run_left  = 0;
		run_level = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = stall_mode_e'($urandom_range(0, 3));
			span = $urandom_range(32, 200);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: begin
						if (run_left == 0) begin
							run_level = ~run_level;
							run_left  = $urandom_range(1, 12);
						end
						run_left--;
						out_stall <= run_level;
					end
				endcase
			end
		end
	end

	// Presents one register write; the caller drops valid after the last one.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Loads a full register setting, plus one write to an index past the list.
	task automatic apply_setting(input setting_e setting);
		logic [31:0] cs;
		logic [31:0] ce;
		logic [31:0] vb;
		logic [31:0] hd;
		logic [31:0] lb;
		logic [31:0] en;
		case (setting)
			SET_ZERO: begin
				cs = '0; ce = '0; vb = '0; hd = '0; lb = '0; en = '0;
				data_lo = '0;
				data_hi = '0;
			end
			SET_ONES: begin
				cs = '0; ce = '1; vb = $urandom; hd = '1; lb = '1; en = '0;
				data_lo = '0;
				data_hi = '1;
			end
			SET_OVERFLOW: begin
				cs = 32'hFFFF_FFFF - $urandom_range(0, 80);
				ce = '1;
				vb = $urandom;
				hd = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
				lb = $urandom;
				en = $urandom;
				data_lo = '0;
				data_hi = 32'h8000_0000;
			end
			SET_SHORT: begin
				cs = $urandom_range(0, 3);
				ce = $urandom_range(0, 8);
				vb = 32'h1000;
				hd = $urandom_range(0, 4);
				lb = 32'h40_0000;
				en = '0;
				data_lo = '0;
				data_hi = '1;
			end
			default: begin
				cs = 32'h400 + ($urandom_range(0, 7) << 9);
				ce = cs + $urandom_range(16, 300);
				vb = 32'h1000;
				hd = ($urandom_range(0, 1) == 0) ? 32'h3FF : cs + $urandom_range(0, 40);
				lb = 32'h40_0000;
				en = lb + vb + $urandom_range(0, 60);
				data_lo = 32'h40_2000 + $urandom_range(0, 255);
				data_hi = data_lo + $urandom_range(0, 32'h800);
			end
		endcase
		write_reg(REG_CODE_START, cs);
		write_reg(REG_CODE_END, ce);
		write_reg(REG_CODE_VBASE, vb);
		write_reg(REG_HEADER, hd);
		write_reg(REG_LOAD_BASE, lb);
		write_reg(REG_ENTRY, en);
		write_reg(REG_DATA_LOW, data_lo);
		write_reg(REG_DATA_HIGH, data_hi);
		write_reg(IDX_W'(NUM_REGS + $urandom_range(0, 20)), $urandom);
		cfg_valid <= 1'b0;
		gap_max = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
	endtask

	// Builds a stream of random bytes seeded with prologues and mov-immediates.
	task automatic build_stream(input int len);
		logic [31:0] imm;
		int          pick;
		stream_q.delete();
		while (stream_q.size() < len) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: begin
					stream_q.push_back(OP_PUSH_EBP);
					stream_q.push_back(OP_MOV_RM);
					stream_q.push_back(OP_MODRM_E5);
				end
				1: begin
					stream_q.push_back(OP_PUSH_EBX);
					stream_q.push_back(OP_PUSH_ESI);
					stream_q.push_back(OP_PUSH_EDI);
					stream_q.push_back(OP_PUSH_EBP);
				end
				2: begin
					stream_q.push_back(OP_PUSH_EBP);
					stream_q.push_back(OP_MOV_R);
					stream_q.push_back(OP_MODRM_EC);
				end
				3, 4: begin
					case ($urandom_range(0, 5))
						0: imm = data_lo;
						1: imm = data_hi - 32'd1;
						2: imm = data_hi;
						3: imm = $urandom;
						default: imm = (data_hi > data_lo) ?
							data_lo + ($urandom % (data_hi - data_lo)) : data_lo;
					endcase
					stream_q.push_back(8'(OP_MOV_IMM_LO + $urandom_range(0, 7)));
					stream_q.push_back(imm[7:0]);
					stream_q.push_back(imm[15:8]);
					stream_q.push_back(imm[23:16]);
					stream_q.push_back(imm[31:24]);
				end
				default: stream_q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		while (stream_q.size() > len)
			void'(stream_q.pop_back());
	endtask

	// Offers one byte and holds it until it is taken.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		in_valid   <= 1'b1;
		image_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Sends the built stream in bursts with random gaps; the last byte is marked final.
	task automatic send_stream();
		int gap;
		for (int i = 0; i < stream_q.size(); i++) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, gap_max);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			send_byte(stream_q[i], i == stream_q.size() - 1);
			burst_left--;
		end
	endtask

	// Idles the input until every expected word has come and the pipeline is empty.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (hits_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus: register settings, each followed by a few streams, then the verdict.
	initial begin
		int len;
		int n_streams;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (items_sent < TARGET_ITEMS) begin
			drain_results();
			apply_setting(setting_e'($urandom_range(0, 4)));
			n_streams = $urandom_range(1, 3);
			for (int k = 0; k < n_streams && items_sent < TARGET_ITEMS; k++) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : $urandom_range(20, 120);
				if (len > TARGET_ITEMS - items_sent)
					len = TARGET_ITEMS - items_sent;
				build_stream(len);
				send_stream();
			end
		end
		drain_results();
		if (mismatches == 0 && hits_pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
